@@ rtl/circ_pkg.sv @@
package circ_pkg;

    localparam int RADIUS_BITS = 11;
    localparam int STEP_W      = RADIUS_BITS + 1;
    localparam int DEC_W       = RADIUS_BITS + 4;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 16;
    localparam int BEATS       = 8;
    localparam int BEAT_W      = $clog2(BEATS);

    typedef enum logic {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } t_func;

    // one step's worth of point data, handed from the stepper to the emitter
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COLOR_W-1:0] color;
        logic [STEP_W-1:0]  a;
        logic [STEP_W-1:0]  b;
        logic               done;
    } t_snap;

endpackage

@@ rtl/circle_outline_rasterizer_top.sv @@
// The first point of an advance appears in the cycle after the beat is taken.
// An advance yields eight points at one point per cycle while the output is not stalled;
// the single output port sets that rate.
// The next beat is taken in the same cycle the eighth point of the last step leaves.
// Reset (synchronous, active low) empties the output and leaves the generator idle.
module circle_outline_rasterizer_top
    import circ_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_func,
    input  logic [COORD_W-1:0]     i_center_x,
    input  logic [COORD_W-1:0]     i_center_y,
    input  logic [RADIUS_BITS-1:0] i_radius,
    input  logic [COLOR_W-1:0]     i_color,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [COORD_W-1:0]     o_pixel_x,
    output logic [COORD_W-1:0]     o_pixel_y,
    output logic [COLOR_W-1:0]     o_pixel_color,
    output logic                   o_last_of_step,
    output logic                   o_circle_done
);

    logic  emit_ready;
    logic  take;
    logic  fire;
    t_snap snap;
    t_func func;

    assign o_stall = !emit_ready;
    assign take    = i_valid && emit_ready;
    assign func    = t_func'(i_func);

    circ_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_func     (func),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_color    (i_color),
        .o_fire     (fire),
        .o_snap     (snap)
    );

    circ_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (fire),
        .i_snap         (snap),
        .o_ready        (emit_ready),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

endmodule

@@ rtl/circ_step.sv @@
module circ_step
    import circ_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  t_func                  i_func,
    input  logic [COORD_W-1:0]     i_center_x,
    input  logic [COORD_W-1:0]     i_center_y,
    input  logic [RADIUS_BITS-1:0] i_radius,
    input  logic [COLOR_W-1:0]     i_color,
    output logic                   o_fire,
    output t_snap                  o_snap
);

    logic [COORD_W-1:0] r_ctr_x;
    logic [COORD_W-1:0] r_ctr_y;
    logic [COLOR_W-1:0] r_color;
    logic [STEP_W-1:0]  r_a;
    logic [STEP_W-1:0]  r_b;
    logic [DEC_W-1:0]   r_d;
    logic               r_active;

    logic [STEP_W-1:0]  n_a;
    logic [STEP_W-1:0]  n_b;
    logic [DEC_W-1:0]   n_d;
    logic [DEC_W-1:0]   a_ext;
    logic [DEC_W-1:0]   b_ext;
    logic               n_done;

    always_comb begin
        a_ext = DEC_W'(signed'(r_a));
        b_ext = DEC_W'(signed'(r_b));
        n_a   = r_a + STEP_W'(1);
        if (r_d[DEC_W-1]) begin
            n_d = r_d + (a_ext << 2) + DEC_W'(6);
            n_b = r_b;
        end else begin
            n_d = r_d + ((a_ext - b_ext) << 2) + DEC_W'(10);
            n_b = r_b - STEP_W'(1);
        end
        n_done = signed'(n_a) > signed'(n_b);
    end

    assign o_fire = i_take && (i_func == FUNC_ADVANCE) && r_active;

    always_comb begin
        o_snap.cx    = r_ctr_x;
        o_snap.cy    = r_ctr_y;
        o_snap.color = r_color;
        o_snap.a     = r_a;
        o_snap.b     = r_b;
        o_snap.done  = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr_x  <= '0;
            r_ctr_y  <= '0;
            r_color  <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_d      <= '0;
            r_active <= 1'b0;
        end else if (i_take && i_func == FUNC_START) begin
            r_ctr_x  <= i_center_x;
            r_ctr_y  <= i_center_y;
            r_color  <= i_color;
            r_a      <= '0;
            r_b      <= STEP_W'(i_radius);
            r_d      <= DEC_W'(3) - (DEC_W'(i_radius) << 1);
            r_active <= 1'b1;
        end else if (o_fire) begin
            r_a <= n_a;
            r_b <= n_b;
            r_d <= n_d;
            if (n_done) begin
                r_active <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/circ_emit.sv @@
module circ_emit
    import circ_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_snap              i_snap,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_last_of_step,
    output logic               o_circle_done
);

    t_snap              r_snap;
    logic               r_busy;
    logic [BEAT_W-1:0]  r_beat;

    logic               last_beat;
    logic [COORD_W-1:0] a_ext;
    logic [COORD_W-1:0] b_ext;
    logic [COORD_W-1:0] x_off;
    logic [COORD_W-1:0] y_off;

    assign last_beat = (r_beat == BEAT_W'(BEATS - 1));
    // free now, or the final beat of the current step leaves this cycle
    assign o_ready   = !r_busy || (last_beat && !i_stall);

    always_comb begin
        a_ext = COORD_W'(signed'(r_snap.a));
        b_ext = COORD_W'(signed'(r_snap.b));
        // beat bit 2 swaps the octant pair, bit 1 negates x, bit 0 negates y
        x_off = r_beat[2] ? b_ext : a_ext;
        y_off = r_beat[2] ? a_ext : b_ext;
        o_pixel_x = r_beat[1] ? (r_snap.cx - x_off) : (r_snap.cx + x_off);
        o_pixel_y = r_beat[0] ? (r_snap.cy - y_off) : (r_snap.cy + y_off);
    end

    assign o_valid        = r_busy;
    assign o_pixel_color  = r_snap.color;
    assign o_last_of_step = last_beat;
    assign o_circle_done  = last_beat && r_snap.done;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap <= i_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_beat <= '0;
        end else if (r_busy && !i_stall) begin
            // advance to the next point, drop busy after the eighth
            if (last_beat) begin
                r_busy <= 1'b0;
            end
            r_beat <= r_beat + BEAT_W'(1);
        end
    end

endmodule

@@ tb/circle_outline_rasterizer_top_test.sv @@
module circle_outline_rasterizer_top_test;
    import circ_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
        logic               done;
    } t_pixel;

    class pixel_board;
        logic [COORD_W-1:0]       ctr_x;
        logic [COORD_W-1:0]       ctr_y;
        logic [COLOR_W-1:0]       pen;
        logic signed [STEP_W-1:0] step_a;
        logic signed [STEP_W-1:0] step_b;
        logic signed [DEC_W-1:0]  decision;
        bit                       active;
        t_pixel                   want[$];
        int                       errors;

        function new();
            ctr_x    = '0;
            ctr_y    = '0;
            pen      = '0;
            step_a   = '0;
            step_b   = '0;
            decision = '0;
            active   = 1'b0;
            errors   = 0;
        endfunction

        function int pending();
            return want.size();
        endfunction

        function void emit(input logic [COORD_W-1:0] x, y, input logic last, done);
            t_pixel p;
            p.x     = x;
            p.y     = y;
            p.color = pen;
            p.last  = last;
            p.done  = done;
            want.push_back(p);
        endfunction

        // Update the circle state for one accepted beat and, for an advance while active, queue its eight points.
        function void note_beat(input t_func f, input logic [COORD_W-1:0] cx, cy,
                                input logic [RADIUS_BITS-1:0] r,
                                input logic [COLOR_W-1:0] col);
            int a, b, d, na, nb;
            bit fin;
            if (f == FUNC_START) begin
                ctr_x    = cx;
                ctr_y    = cy;
                pen      = col;
                step_a   = '0;
                step_b   = STEP_W'(r);
                decision = DEC_W'(3 - 2 * int'(r));
                active   = 1'b1;
                return;
            end
            if (!active)
                return;
            a  = step_a;
            b  = step_b;
            d  = decision;
            nb = b;
            if (d < 0) begin
                d = d + 4 * a + 6;
            end else begin
                d  = d + 4 * (a - b) + 10;
                nb = b - 1;
            end
            na       = a + 1;
            step_a   = STEP_W'(na);
            step_b   = STEP_W'(nb);
            decision = DEC_W'(d);
            fin      = step_a > step_b;
            if (fin)
                active = 1'b0;
            emit(ctr_x + COORD_W'(a), ctr_y + COORD_W'(b), 1'b0, 1'b0);
            emit(ctr_x + COORD_W'(a), ctr_y - COORD_W'(b), 1'b0, 1'b0);
            emit(ctr_x - COORD_W'(a), ctr_y + COORD_W'(b), 1'b0, 1'b0);
            emit(ctr_x - COORD_W'(a), ctr_y - COORD_W'(b), 1'b0, 1'b0);
            emit(ctr_x + COORD_W'(b), ctr_y + COORD_W'(a), 1'b0, 1'b0);
            emit(ctr_x + COORD_W'(b), ctr_y - COORD_W'(a), 1'b0, 1'b0);
            emit(ctr_x - COORD_W'(b), ctr_y + COORD_W'(a), 1'b0, 1'b0);
            emit(ctr_x - COORD_W'(b), ctr_y - COORD_W'(a), 1'b1, fin);
        endfunction

        function void check_pixel(input logic [COORD_W-1:0] x, y,
                                  input logic [COLOR_W-1:0] col,
                                  input logic last, done);
            t_pixel w;
            if (want.size() == 0) begin
                $error("unexpected pixel x=%h y=%h color=%h", x, y, col);
                errors++;
                return;
            end
            w = want.pop_front();
            if (x !== w.x) begin
                $error("pixel_x: expected %h, got %h", w.x, x);
                errors++;
            end
            if (y !== w.y) begin
                $error("pixel_y: expected %h, got %h", w.y, y);
                errors++;
            end
            if (col !== w.color) begin
                $error("pixel_color: expected %h, got %h", w.color, col);
                errors++;
            end
            if (last !== w.last) begin
                $error("last_of_step: expected %b, got %b", w.last, last);
                errors++;
            end
            if (done !== w.done) begin
                $error("circle_done: expected %b, got %b", w.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_func;
    logic [COORD_W-1:0]     i_center_x;
    logic [COORD_W-1:0]     i_center_y;
    logic [RADIUS_BITS-1:0] i_radius;
    logic [COLOR_W-1:0]     i_color;
    logic                   o_valid;
    logic                   i_stall;
    logic [COORD_W-1:0]     o_pixel_x;
    logic [COORD_W-1:0]     o_pixel_y;
    logic [COLOR_W-1:0]     o_pixel_color;
    logic                   o_last_of_step;
    logic                   o_circle_done;

    pixel_board board;
    int         hold_len;
    bit         quiet;
    int         items_sent;
    int         cycles;

    circle_outline_rasterizer_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_color        (i_color),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                board.check_pixel(o_pixel_x, o_pixel_y, o_pixel_color,
                                  o_last_of_step, o_circle_done);
            if (i_valid && !o_stall)
                board.note_beat(t_func'(i_func), i_center_x, i_center_y, i_radius, i_color);
        end
    end

    // Output side: random stall bursts, one long hold-off on request, none when quiet.
    initial begin
        int run;
        bit hold_off;
        i_stall = 1'b0;
        run     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_len != 0) begin
                i_stall = 1'b1;
                repeat (hold_len - 1) @(negedge i_clk);
                hold_len = 0;
                run      = 0;
            end else if (quiet) begin
                i_stall = 1'b0;
            end else begin
                if (run == 0) begin
                    hold_off = ($urandom_range(0, 3) == 0);
                    run      = hold_off ? $urandom_range(1, 8) : $urandom_range(1, 12);
                    i_stall  = hold_off;
                end
                run--;
            end
        end
    end

    task automatic send_item(input t_func f, input logic [COORD_W-1:0] cx, cy,
                             input logic [RADIUS_BITS-1:0] r,
                             input logic [COLOR_W-1:0] col);
        int gap;
        @(negedge i_clk);
        i_valid    = 1'b1;
        i_func     = f;
        i_center_x = cx;
        i_center_y = cy;
        i_radius   = r;
        i_color    = col;
        do @(posedge i_clk); while (o_stall);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic advance(input int n);
        repeat (n)
            send_item(FUNC_ADVANCE, COORD_W'($urandom), COORD_W'($urandom),
                      RADIUS_BITS'($urandom), COLOR_W'($urandom));
    endtask

    task automatic random_circle(input int steps);
        logic [COORD_W-1:0]     cx;
        logic [COORD_W-1:0]     cy;
        logic [COLOR_W-1:0]     col;
        logic [RADIUS_BITS-1:0] r;
        int                     pick;
        // stray advance: continues the old circle or is dropped while idle
        if ($urandom_range(0, 5) == 0)
            advance(1);
        cx = COORD_W'($urandom);
        cy = COORD_W'($urandom);
        col = COLOR_W'($urandom);
        if ($urandom_range(0, 4) == 0)
            cx = {COORD_W{cx[0]}};
        if ($urandom_range(0, 4) == 0)
            cy = {COORD_W{cy[0]}};
        pick = $urandom_range(0, 9);
        if (pick < 6)
            r = RADIUS_BITS'($urandom_range(0, 12));
        else if (pick < 9)
            r = RADIUS_BITS'($urandom);
        else
            r = {RADIUS_BITS{1'b1}};
        send_item(FUNC_START, cx, cy, r, col);
        advance(steps);
        items_sent += 1 + steps;
    endtask

    task automatic run_random(input int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop)
            random_circle($urandom_range(0, 12));
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        board      = new();
        hold_len   = 0;
        quiet      = 1'b0;
        items_sent = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_func     = FUNC_START;
        i_center_x = '0;
        i_center_y = '0;
        i_radius   = '0;
        i_color    = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // advance while idle gives nothing
        send_item(FUNC_ADVANCE, 16'hFFFF, 16'hFFFF, {RADIUS_BITS{1'b1}}, 16'hFFFF);
        // zero radius: centre eight times, then done
        send_item(FUNC_START, 16'h0000, 16'h0000, '0, 16'hFFFF);
        advance(2);
        // largest radius at the top corner: coordinates wrap
        send_item(FUNC_START, 16'hFFFF, 16'hFFFF, {RADIUS_BITS{1'b1}}, 16'h0000);
        advance(3);
        // restart while a circle is running
        send_item(FUNC_START, 16'd100, 16'd200, 11'd5, 16'h1234);
        advance(1);
        send_item(FUNC_START, 16'h8000, 16'h7FFF, 11'd3, 16'hF800);
        advance(4);
        send_item(FUNC_START, 16'h0000, 16'hFFFF, 11'd1, 16'h07E0);
        advance(1);
        send_item(FUNC_START, 16'hFFFF, 16'h0000, {RADIUS_BITS{1'b1}}, 16'h001F);
        advance(1);

        run_random(35);

        // fill the block against a held-off receiver
        hold_len = HOLD_CYCLES;
        random_circle(12);

        @(negedge i_clk);
        i_valid = 1'b0;
        wait_drained();

        run_random(30);

        quiet = 1'b1;
        run_random(20);

        @(negedge i_clk);
        i_valid = 1'b0;
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ circle_outline_rasterizer_top.f @@
rtl/circ_pkg.sv
rtl/circ_step.sv
rtl/circ_emit.sv
rtl/circle_outline_rasterizer_top.sv
tb/circle_outline_rasterizer_top_test.sv
